### sv/temp_scratchpad_crc_convert_defines.svh
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_convert_defines
// assertion macros used by the checker file of the block (tsc_checker)
// ----------------------------------------------------------------------------
`ifndef TEMP_SCRATCHPAD_CRC_CONVERT_DEFINES_SVH
`define TEMP_SCRATCHPAD_CRC_CONVERT_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define TSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, masked while reset is low
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also covers the reset cycles
`define TSC_ASSERT_NEXT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed during reset");

`endif

### sv/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// constants and the crc-8 update shared by the scratchpad decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FRAC_W    = 10;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned PROD_W    = 14;
  localparam int unsigned FRAC_DIV  = 1000;

  localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h8C;
  localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 10'd625;
  localparam logic [TEMP_W-1:0] NIBBLE_MASK = 16'h000F;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [TEMP_W-1:0] temp_t;
  typedef logic [FRAC_W-1:0] frac_t;

  // reflected crc-8, one byte, lsb first
  function automatic byte_t crc8_update(input byte_t crc, input byte_t data);
    byte_t c;
    c = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### sv/temp_scratchpad_crc_convert.sv
// ----------------------------------------------------------------------------
// temp_scratchpad_crc_convert
// crc-8 check and temperature decode over a sensor scratchpad
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_scratch_byte[7:0]
// out     | output    | out_valid / out_ready| out_temp_tenths[15:0], out_crc_error
// cfg     | input     | cfg_valid / cfg_ready| cfg_frac_per_lsb[9:0]
//
// one byte per cycle while no result is stalled; each byte passes through the
// input register, and the last byte of a scratchpad lands its result in the
// output register once that register is free
// rate is set by the combinational crc update and the output register
// rst_n is synchronous; it clears counters, crc, held bytes and valids
// a stalled result holds only the last byte of the next scratchpad
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module temp_scratchpad_crc_convert #(
  parameter int unsigned SCRATCH_BYTES = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tsc_pkg::byte_t in_scratch_byte,
  output logic           out_valid,
  input  logic           out_ready,
  output tsc_pkg::temp_t out_temp_tenths,
  output logic           out_crc_error,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  tsc_pkg::frac_t cfg_frac_per_lsb
);
  import tsc_pkg::*;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SCRATCH_BYTES - 1);

  logic              s1_valid_r;
  byte_t             s1_byte_r;
  logic [CNT_W-1:0]  cnt_r;
  byte_t             crc_r;
  byte_t             low_r;
  byte_t             high_r;
  frac_t             frac_r;
  logic              out_valid_r;
  temp_t             out_tenths_r;
  logic              out_err_r;

  byte_t             crc_nxt;
  logic              is_last;
  logic              out_free;
  logic              s1_go;
  temp_t             tenths;

  assign crc_nxt  = crc8_update(crc_r, s1_byte_r);
  assign is_last  = cnt_r == LAST_IDX;
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!is_last || out_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  tsc_convert u_convert (
    .reading      ({high_r, low_r}),
    .frac_per_lsb (frac_r),
    .tenths       (tenths)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frac_r <= cfg_frac_per_lsb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_scratch_byte;
    end
  end

  // scratchpad state; bytes 0 and 1 are in place before the last byte when SCRATCH_BYTES is at least 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      crc_r  <= CRC_INIT;
      low_r  <= '0;
      high_r <= '0;
    end else if (s1_go) begin
      if (is_last) begin
        cnt_r  <= '0;
        crc_r  <= CRC_INIT;
        low_r  <= '0;
        high_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
        crc_r <= crc_nxt;
        if (cnt_r == '0) begin
          low_r <= s1_byte_r;
        end
        if (cnt_r == CNT_W'(1)) begin
          high_r <= s1_byte_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && is_last) begin
      out_err_r    <= crc_nxt != CRC_INIT;
      out_tenths_r <= (crc_nxt != CRC_INIT) ? '0 : tenths;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temp_tenths = out_tenths_r;
  assign out_crc_error   = out_err_r;

endmodule

### sv/tsc_convert.sv
// ----------------------------------------------------------------------------
// tsc_convert
// raw 16-bit reading to tenths of a degree: whole * 10 + nibble * frac / 1000
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsc_convert (
  input  tsc_pkg::temp_t reading,
  input  tsc_pkg::frac_t frac_per_lsb,
  output tsc_pkg::temp_t tenths
);
  import tsc_pkg::*;

  localparam int unsigned STEPS = 15;

  logic [TEMP_W-1:0]   whole;
  logic [TEMP_W-1:0]   whole_x10;
  logic [NIBBLE_W-1:0] nibble;
  logic [PROD_W-1:0]   prod;
  logic [STEPS-1:0]    ge;
  logic [NIBBLE_W-1:0] quot;

  assign whole     = reading >> NIBBLE_W;
  assign whole_x10 = (whole << 3) + (whole << 1);
  assign nibble    = NIBBLE_W'(reading & NIBBLE_MASK);
  assign prod      = PROD_W'(nibble * frac_per_lsb);

  // quotient stays below 16, so compare against each multiple of the divisor
  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      ge[i] = prod >= PROD_W'((i + 1) * FRAC_DIV);
    end
  end

  assign quot   = NIBBLE_W'($countones(ge));
  assign tenths = whole_x10 + TEMP_W'(quot);

endmodule

### sv/tsc_checker.sv
// ----------------------------------------------------------------------------
// tsc_checker
// port-level checks on the result channel of the scratchpad decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "temp_scratchpad_crc_convert_defines.svh"

module tsc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input tsc_pkg::temp_t out_temp_tenths,
  input logic           out_crc_error
);
  import tsc_pkg::*;

  // largest legal reading: 4095 whole degrees plus a fraction term of 15
  localparam temp_t TENTHS_MAX = 16'd40965;

  `TSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_temp_tenths) && $stable(out_crc_error))
  `TSC_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && out_crc_error, out_temp_tenths == '0)
  `TSC_ASSERT_SAME(a_range, clk, rst_n, out_valid && !out_crc_error, out_temp_tenths <= TENTHS_MAX)
  `TSC_ASSERT_NEXT_RST(a_rst_clear, clk, !rst_n, !out_valid)

endmodule

bind temp_scratchpad_crc_convert tsc_checker u_tsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_temp_tenths (out_temp_tenths),
  .out_crc_error   (out_crc_error)
);

### tb/tsc_scratchpad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_scratchpad_checker
// watches the byte, result and register channels of the scratchpad decoder,
// keeps its own crc-8 and reading decode, and compares every result in order
// ----------------------------------------------------------------------------

module tsc_scratchpad_checker #(
  parameter int unsigned SCRATCH_BYTES = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  tsc_pkg::byte_t in_scratch_byte,
  input  logic           out_valid,
  input  logic           out_ready,
  input  tsc_pkg::temp_t out_temp_tenths,
  input  logic           out_crc_error,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  tsc_pkg::frac_t cfg_frac_per_lsb,
  output int unsigned    fail_count,
  output int unsigned    pending_count,
  output int unsigned    reading_count,
  output int unsigned    crc_fail_count
);

  typedef struct packed {
    tsc_pkg::temp_t tenths;
    logic           crc_error;
  } reading_t;

  reading_t       expected_readings[$];
  tsc_pkg::frac_t frac_factor = tsc_pkg::FRAC_RESET;
  int unsigned    bytes_seen = 0;
  tsc_pkg::byte_t crc_acc = tsc_pkg::CRC_INIT;
  tsc_pkg::byte_t byte_lo = '0;
  tsc_pkg::byte_t byte_hi = '0;
  int unsigned    n_fail = 0;
  int unsigned    n_readings = 0;
  int unsigned    n_crc_fail = 0;

  // reflected crc-8, lsb first
  function automatic tsc_pkg::byte_t crc8_step(input tsc_pkg::byte_t crc,
                                               input tsc_pkg::byte_t data);
    tsc_pkg::byte_t c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ tsc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic reading_t decode_reading(input tsc_pkg::byte_t lo,
                                              input tsc_pkg::byte_t hi,
                                              input tsc_pkg::byte_t residue,
                                              input tsc_pkg::frac_t frac);
    logic [15:0] raw;
    int unsigned tenths;
    reading_t    r;
    raw    = {hi, lo};
    tenths = int'(raw >> 4) * 10
           + int'(raw & tsc_pkg::NIBBLE_MASK) * int'(frac) / tsc_pkg::FRAC_DIV;
    if (residue != 8'h00) begin
      r.tenths    = '0;
      r.crc_error = 1'b1;
    end else begin
      r.tenths    = tenths[15:0];
      r.crc_error = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      frac_factor = tsc_pkg::FRAC_RESET;
      bytes_seen  = 0;
      crc_acc     = tsc_pkg::CRC_INIT;
      byte_lo     = '0;
      byte_hi     = '0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        frac_factor = cfg_frac_per_lsb;
      end
      if (in_valid && in_ready) begin
        crc_acc = crc8_step(crc_acc, in_scratch_byte);
        if (bytes_seen == 0) begin
          byte_lo = in_scratch_byte;
        end else if (bytes_seen == 1) begin
          byte_hi = in_scratch_byte;
        end
        bytes_seen++;
        if (bytes_seen == SCRATCH_BYTES) begin
          expected_readings.push_back(decode_reading(byte_lo, byte_hi, crc_acc,
                                                     frac_factor));
          bytes_seen = 0;
          crc_acc    = tsc_pkg::CRC_INIT;
          byte_lo    = '0;
          byte_hi    = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          n_fail++;
          $error("result with no reading pending: temp_tenths %0d crc_error %0b",
                 out_temp_tenths, out_crc_error);
        end else begin
          want = expected_readings.pop_front();
          if (out_temp_tenths !== want.tenths) begin
            n_fail++;
            $error("temp_tenths mismatch: expected %0d, actual %0d",
                   want.tenths, out_temp_tenths);
          end
          if (out_crc_error !== want.crc_error) begin
            n_fail++;
            $error("crc_error mismatch: expected %0b, actual %0b",
                   want.crc_error, out_crc_error);
          end
          n_readings++;
          if (want.crc_error) begin
            n_crc_fail++;
          end
        end
      end
    end
    fail_count     <= n_fail;
    pending_count  <= expected_readings.size();
    reading_count  <= n_readings;
    crc_fail_count <= n_crc_fail;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives scratchpads into the decoder under random stalls, several fraction
// factors and one long output hold-off; the checker judges every reading
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned SCRATCH_BYTES    = 9;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned FRAMES_PER_PHASE = 30;
  localparam int unsigned HOLD_AT          = 1200;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LIMIT_NS         = 200000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  tsc_pkg::byte_t in_scratch_byte = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  tsc_pkg::temp_t out_temp_tenths;
  logic           out_crc_error;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  tsc_pkg::frac_t cfg_frac_per_lsb = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned reading_count;
  int unsigned crc_fail_count;

  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 54;
  int unsigned requests_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  temp_scratchpad_crc_convert #(
    .SCRATCH_BYTES(SCRATCH_BYTES)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_scratch_byte (in_scratch_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_temp_tenths (out_temp_tenths),
    .out_crc_error   (out_crc_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_frac_per_lsb(cfg_frac_per_lsb)
  );

  tsc_scratchpad_checker #(
    .SCRATCH_BYTES(SCRATCH_BYTES)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_scratch_byte (in_scratch_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_temp_tenths (out_temp_tenths),
    .out_crc_error   (out_crc_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_frac_per_lsb(cfg_frac_per_lsb),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .reading_count   (reading_count),
    .crc_fail_count  (crc_fail_count)
  );

  // receiver: random stalls, plus one long hold-off once enough requests went in
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      requests_seen <= requests_seen + 1;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && requests_seen >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // builds the trailing crc byte of a well-formed scratchpad
  function automatic tsc_pkg::byte_t crc8_byte(input tsc_pkg::byte_t crc,
                                               input tsc_pkg::byte_t data);
    tsc_pkg::byte_t c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 8'h8C;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  task automatic push_byte(input tsc_pkg::byte_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_scratch_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_stray(input int unsigned count);
    repeat (count) push_byte(tsc_pkg::byte_t'($urandom_range(255)));
  endtask

  // fill < 0 gives random filler bytes
  task automatic send_frame(input tsc_pkg::byte_t lo, input tsc_pkg::byte_t hi,
                            input int fill, input bit corrupt);
    tsc_pkg::byte_t frame [SCRATCH_BYTES];
    tsc_pkg::byte_t crc;
    int unsigned    pos;
    int unsigned    bit_pos;
    crc      = '0;
    frame[0] = lo;
    frame[1] = hi;
    for (int k = 2; k < SCRATCH_BYTES - 1; k++) begin
      if (fill < 0) begin
        frame[k] = tsc_pkg::byte_t'($urandom_range(255));
      end else begin
        frame[k] = fill[7:0];
      end
    end
    for (int k = 0; k < SCRATCH_BYTES - 1; k++) begin
      crc = crc8_byte(crc, frame[k]);
    end
    frame[SCRATCH_BYTES-1] = crc;
    if (corrupt) begin
      pos     = $urandom_range(SCRATCH_BYTES - 1);
      bit_pos = $urandom_range(7);
      frame[pos][bit_pos] = ~frame[pos][bit_pos];
    end
    for (int k = 0; k < SCRATCH_BYTES; k++) begin
      push_byte(frame[k]);
    end
  endtask

  task automatic random_frame();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      send_frame(tsc_pkg::byte_t'($urandom_range(255)),
                 tsc_pkg::byte_t'($urandom_range(255)), -1, 1'b0);
    end else if (pick < 92) begin
      send_frame(tsc_pkg::byte_t'($urandom_range(255)),
                 tsc_pkg::byte_t'($urandom_range(255)), -1, 1'b1);
    end else begin
      // pure noise, the crc almost never closes
      push_stray(SCRATCH_BYTES);
    end
  endtask

  task automatic write_frac(input tsc_pkg::frac_t value);
    cfg_valid        <= 1'b1;
    cfg_frac_per_lsb <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    tsc_pkg::frac_t frac;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        tx_idle_pct = 37;
        rx_idle_pct <= 54;
      end else if (phase < 4) begin
        tx_idle_pct = 54;
        rx_idle_pct <= 37;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      case (phase)
        0: frac = 10'd625;
        1: frac = 10'd0;
        2: frac = 10'd1000;
        3: frac = 10'd1023;
        4: frac = tsc_pkg::frac_t'($urandom_range(1023));
        default: frac = 10'd1;
      endcase
      write_frac(frac);
      if (phase == 0) begin
        send_frame(8'h00, 8'h00, 0, 1'b0);
        send_frame(8'hFF, 8'hFF, 255, 1'b0);
        send_frame(8'h50, 8'h05, -1, 1'b1);
      end
      // finish the scratchpad left open across the register write
      if (phase == 1) begin
        push_stray(SCRATCH_BYTES - 4);
      end
      repeat (FRAMES_PER_PHASE) random_frame();
      if (phase == 0) begin
        push_stray(4);
      end
      in_valid <= 1'b0;
      drain();
    end
    $display("checked %0d readings, %0d of them crc failures, over %0d fraction factors",
             reading_count, crc_fail_count, PHASES);
    $display("input and output stalls both ways, one long output hold-off, and a mid-scratchpad register write");
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
